// ----- rtl/hdf_pkg.sv -----
`default_nettype none

package hdf_pkg;

  // Default depth of the line store and largest bytes per line.
  localparam int unsigned LINE_MAX_DEF = 16;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LW_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b1;

  localparam logic [LW_W-1:0] LW_RESET = 5'd16;

  // Characters used in the dump text.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ALPHA = 8'h37;  // 'A' minus ten

  // Counter limits of the address digits and of the space runs.
  localparam logic [2:0] ADDR_LAST_DIGIT = 3'd7;
  localparam logic [2:0] SPACE_LAST      = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ADDR_SP,
    ST_HEX_HI,
    ST_HEX_LO,
    ST_HEX_SP,
    ST_HEX_SP4,
    ST_PAD,
    ST_PAD4,
    ST_GAP,
    ST_ASCII,
    ST_CR,
    ST_LF
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_ADDR,
    CH_HEX_HI,
    CH_HEX_LO,
    CH_ASCII,
    CH_CR,
    CH_LF
  } char_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take;        // input may be accepted
    logic      push;        // a character is offered this cycle
    char_sel_e sel;         // source of that character
    logic [2:0] nib;        // address digit, most significant first
    logic      final_char;  // last character caused by the current byte
    logic      line_close;  // the line ends with this character
    logic      col_step;    // the line continues at the next column
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic adv;          // a character offered now is taken
    logic col_zero;     // the next accepted byte opens a line
    logic line_done;
    logic extra4;       // an extra space follows this column
    logic pad_needed;
    logic gap_needed;
  } status_t;

  // Uppercase hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHAR_ZERO + {4'h0, v};
    end else begin
      r = CHAR_ALPHA + {4'h0, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hdf_stream_if.sv -----
`default_nettype none

// Byte stream into the formatter.
interface hdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Packed text items out of the formatter.
interface hdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_a;
  logic [7:0] char_b;
  logic [7:0] char_c;
  logic [7:0] char_d;
  logic [2:0] char_count;
  logic       run_end;

  modport source (output valid, output char_a, output char_b, output char_c,
                  output char_d, output char_count, output run_end, input ready);
  modport sink   (input valid, input char_a, input char_b, input char_c,
                  input char_d, input char_count, input run_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/hdf_ctrl.sv -----
`default_nettype none

module hdf_ctrl #(
  parameter int unsigned LINE_MAX = hdf_pkg::LINE_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hdf_pkg::status_t               st_i,
  input  wire logic [$clog2(LINE_MAX)-1:0]    col_i,
  input  wire logic [$clog2(LINE_MAX+1)-1:0]  width_i,
  output      hdf_pkg::cmd_t                  cmd_o,
  output      logic [$clog2(LINE_MAX)-1:0]    rd_idx_o
);
  import hdf_pkg::*;

  localparam int unsigned CW = $clog2(LINE_MAX);
  localparam int unsigned WW = $clog2(LINE_MAX + 1);

  ctrl_state_e   state_q, state_d;
  logic [2:0]    sub_q, sub_d;
  logic [CW-1:0] idx_q, idx_d;

  // Targets shared by several states.
  ctrl_state_e   tail_state;
  ctrl_state_e   hex_done_state;
  logic [CW-1:0] hex_done_idx;
  logic          pad_last;

  // Hex field ends in padding if the line is short; then the gap space if the width needs one, else the ASCII column.
  always_comb begin
    tail_state = st_i.gap_needed ? ST_GAP : ST_ASCII;
    pad_last   = ((WW'(idx_q) + WW'(1)) == width_i);
    if (st_i.pad_needed) begin
      hex_done_state = ST_PAD;
      hex_done_idx   = col_i + CW'(1);
    end else begin
      hex_done_state = tail_state;
      hex_done_idx   = '0;
    end
  end

  // Next state and sequencing counters.
  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (st_i.in_valid) begin
          sub_d   = '0;
          state_d = st_i.col_zero ? ST_ADDR : ST_HEX_HI;
        end
      end
      ST_ADDR: begin
        if (st_i.adv) begin
          if (sub_q == ADDR_LAST_DIGIT) begin
            sub_d   = '0;
            state_d = ST_ADDR_SP;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end
      end
      ST_ADDR_SP: begin
        if (st_i.adv) begin
          if (sub_q == SPACE_LAST) begin
            state_d = ST_HEX_HI;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end
      end
      ST_HEX_HI: begin
        if (st_i.adv) state_d = ST_HEX_LO;
      end
      ST_HEX_LO: begin
        if (st_i.adv) state_d = ST_HEX_SP;
      end
      ST_HEX_SP: begin
        if (st_i.adv) begin
          if (st_i.extra4) begin
            state_d = ST_HEX_SP4;
          end else if (st_i.line_done) begin
            state_d = hex_done_state;
            idx_d   = hex_done_idx;
            sub_d   = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_HEX_SP4: begin
        if (st_i.adv) begin
          if (st_i.line_done) begin
            state_d = hex_done_state;
            idx_d   = hex_done_idx;
            sub_d   = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD, ST_PAD4: begin
        if (st_i.adv) begin
          if (state_q == ST_PAD && sub_q != SPACE_LAST) begin
            sub_d = sub_q + 3'd1;
          end else if (state_q == ST_PAD && idx_q[1:0] == 2'b11) begin
            state_d = ST_PAD4;
          end else if (pad_last) begin
            state_d = tail_state;
            idx_d   = '0;
          end else begin
            state_d = ST_PAD;
            idx_d   = idx_q + CW'(1);
            sub_d   = '0;
          end
        end
      end
      ST_GAP: begin
        if (st_i.adv) begin
          state_d = ST_ASCII;
          idx_d   = '0;
        end
      end
      ST_ASCII: begin
        if (st_i.adv) begin
          if (idx_q == col_i) begin
            state_d = ST_CR;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      ST_CR: begin
        if (st_i.adv) state_d = ST_LF;
      end
      ST_LF: begin
        if (st_i.adv) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd_o            = '0;
    cmd_o.sel        = CH_SPACE;
    cmd_o.nib        = sub_q;
    unique case (state_q)
      ST_IDLE: cmd_o.take = 1'b1;
      ST_ADDR: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = CH_ADDR;
      end
      ST_ADDR_SP, ST_PAD, ST_PAD4, ST_GAP: cmd_o.push = 1'b1;
      ST_HEX_HI: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = CH_HEX_HI;
      end
      ST_HEX_LO: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = CH_HEX_LO;
      end
      ST_HEX_SP: begin
        cmd_o.push       = 1'b1;
        cmd_o.final_char = !st_i.extra4 && !st_i.line_done;
        cmd_o.col_step   = !st_i.extra4 && !st_i.line_done;
      end
      ST_HEX_SP4: begin
        cmd_o.push       = 1'b1;
        cmd_o.final_char = !st_i.line_done;
        cmd_o.col_step   = !st_i.line_done;
      end
      ST_ASCII: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = CH_ASCII;
      end
      ST_CR: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = CH_CR;
      end
      ST_LF: begin
        cmd_o.push       = 1'b1;
        cmd_o.sel        = CH_LF;
        cmd_o.final_char = 1'b1;
        cmd_o.line_close = 1'b1;
      end
      default: cmd_o.take = 1'b0;
    endcase
  end

  // The line store is read ahead through its registered read port, at the index of the next cycle.
  assign rd_idx_o = idx_d;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sub_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hdf_datapath.sv -----
`default_nettype none

module hdf_datapath #(
  parameter int unsigned LINE_MAX = hdf_pkg::LINE_MAX_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [hdf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [hdf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  hdf_in_if.sink                                   in_i,
  hdf_out_if.source                                out_o,
  input  wire hdf_pkg::cmd_t                       cmd_i,
  input  wire logic [$clog2(LINE_MAX)-1:0]         rd_idx_i,
  output      hdf_pkg::status_t                    st_o,
  output      logic [$clog2(LINE_MAX)-1:0]         col_o,
  output      logic [$clog2(LINE_MAX+1)-1:0]       width_o
);
  import hdf_pkg::*;

  localparam int unsigned CW = $clog2(LINE_MAX);
  localparam int unsigned WW = $clog2(LINE_MAX + 1);

  // Configuration registers.
  logic [31:0]     base_addr_q;
  logic [LW_W-1:0] line_width_q;

  // Line state.
  logic [31:0]   line_addr_q;
  logic [CW-1:0] column_q;
  logic          active_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic [7:0]    store_q [LINE_MAX];

  // Packing and output registers.
  logic [2:0][7:0] pack_q;
  logic [1:0]      pack_cnt_q;
  logic [3:0][7:0] out_char_q;
  logic [2:0]      out_count_q;
  logic            out_end_q;
  logic            out_valid_q;

  logic          accept;
  logic          adv;
  logic          fire;
  logic          emit;
  logic [CW-1:0] wr_col;
  logic [WW-1:0] width;
  logic [WW-1:0] col_inc;
  logic [5:0]    lw_ext;
  logic [7:0]    ch;
  logic [7:0]    rd_byte_q;
  logic [3:0][7:0] item_chars;

  assign accept = in_i.valid && cmd_i.take;
  assign adv    = !out_valid_q || out_o.ready;
  assign fire   = cmd_i.push && adv;
  assign emit   = fire && (pack_cnt_q == 2'd3 || cmd_i.final_char);
  assign wr_col = active_q ? column_q : '0;

  // Width in effect: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    lw_ext = {1'b0, line_width_q};
    if (line_width_q == '0) begin
      width = WW'(1);
    end else if (lw_ext > 6'(LINE_MAX)) begin
      width = WW'(LINE_MAX);
    end else begin
      width = WW'(line_width_q);
    end
  end

  assign col_inc = WW'(column_q) + WW'(1);

  // Status for the controller.
  always_comb begin
    st_o.in_valid   = in_i.valid;
    st_o.adv        = adv;
    st_o.col_zero   = !active_q || (column_q == '0);
    st_o.line_done  = last_q || (col_inc >= width);
    st_o.extra4     = (col_inc[1:0] == 2'b00);
    st_o.pad_needed = (col_inc < width);
    st_o.gap_needed = (width[1:0] != 2'b00);
  end

  assign col_o      = column_q;
  assign width_o    = width;
  assign in_i.ready = cmd_i.take;

  // Registered read of the line store for the ASCII column.
  always_ff @(posedge clk_i) begin
    rd_byte_q <= store_q[rd_idx_i];
  end

  // Character generator.
  always_comb begin
    unique case (cmd_i.sel)
      CH_ADDR:   ch = hex_char(line_addr_q[{~cmd_i.nib, 2'b00} +: 4]);
      CH_HEX_HI: ch = hex_char(byte_q[7:4]);
      CH_HEX_LO: ch = hex_char(byte_q[3:0]);
      CH_ASCII:  ch = (rd_byte_q >= CHAR_SPACE && rd_byte_q <= CHAR_DEL) ? rd_byte_q : CHAR_DOT;
      CH_CR:     ch = CHAR_CR;
      CH_LF:     ch = CHAR_LF;
      CH_SPACE:  ch = CHAR_SPACE;
      default:   ch = CHAR_SPACE;
    endcase
  end

  // Item assembled from the packed characters and the one offered now.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pack_cnt_q) begin
        item_chars[i] = pack_q[i];
      end else if (2'(i) == pack_cnt_q) begin
        item_chars[i] = ch;
      end else begin
        item_chars[i] = '0;
      end
    end
    item_chars[3] = (pack_cnt_q == 2'd3) ? ch : '0;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_addr_q  <= '0;
      line_width_q <= LW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_ADDRESS: base_addr_q  <= cfg_data_i;
        CFG_LINE_WIDTH:   line_width_q <= cfg_data_i[LW_W-1:0];
        default:          base_addr_q  <= base_addr_q;
      endcase
    end
  end

  // Line state: opened by the first byte of a dump, advanced by the last character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_addr_q <= '0;
      column_q    <= '0;
      active_q    <= 1'b0;
    end else if (accept) begin
      if (!active_q) begin
        line_addr_q <= base_addr_q;
        column_q    <= '0;
        active_q    <= 1'b1;
      end
    end else if (fire && cmd_i.line_close) begin
      line_addr_q <= line_addr_q + 32'(width);
      column_q    <= '0;
      if (last_q) active_q <= 1'b0;
    end else if (fire && cmd_i.col_step) begin
      column_q <= col_inc[CW-1:0];
    end
  end

  // Current byte and the line store.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q          <= in_i.data_byte;
      last_q          <= in_i.last_byte;
      store_q[wr_col] <= in_i.data_byte;
    end
  end

  // Packing of characters, four to an item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_cnt_q <= '0;
    end else if (emit) begin
      pack_cnt_q <= '0;
    end else if (fire) begin
      pack_cnt_q <= pack_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !emit) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == pack_cnt_q) pack_q[i] <= ch;
      end
    end
  end

  // Output register: holds an item until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q  <= item_chars;
      out_count_q <= {1'b0, pack_cnt_q} + 3'd1;
      out_end_q   <= cmd_i.final_char;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_a     = out_char_q[0];
  assign out_o.char_b     = out_char_q[1];
  assign out_o.char_c     = out_char_q[2];
  assign out_o.char_d     = out_char_q[3];
  assign out_o.char_count = out_count_q;
  assign out_o.run_end    = out_end_q;

endmodule

`default_nettype wire

// ----- rtl/hex_dump_formatter_unit.sv -----
`default_nettype none

// Channel   Direction  Payload                                         Transfer
// in_i      sink       data_byte[7:0], last_byte                       valid & ready
// out_o     source     char_a..char_d[7:0], char_count[2:0], run_end   valid & ready
// cfg       write      cfg_idx_i, cfg_data_i[31:0]                     cfg_we_i
//
// A byte is taken in the idle state, then its text leaves one character a cycle
// while the output is not stalled, from the character generator, packed four to an
// item in the output register. A mid-line byte gives two hex digits and a space,
// one more after every fourth column; a line-opening byte adds eight address digits
// and three spaces; a line-closing byte adds three spaces per padded column, one more
// after every fourth, the gap space, one character per stored byte and CR LF.
// Reset clears the controller, line state and output valid; the line store is
// not cleared. A stalled output holds the character generator until a transfer.

module hex_dump_formatter_unit #(
  parameter int unsigned LINE_MAX = hdf_pkg::LINE_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hdf_in_if.sink                              in_i,
  hdf_out_if.source                           out_o
);
  import hdf_pkg::*;

  localparam int unsigned CW = $clog2(LINE_MAX);
  localparam int unsigned WW = $clog2(LINE_MAX + 1);

  cmd_t          cmd;
  status_t       st;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] col;
  logic [WW-1:0] width;

  // Sequencer of the text of one byte.
  hdf_ctrl #(
    .LINE_MAX (LINE_MAX)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .st_i     (st),
    .col_i    (col),
    .width_i  (width),
    .cmd_o    (cmd),
    .rd_idx_o (rd_idx)
  );

  // Line state, character generation and output packing.
  hdf_datapath #(
    .LINE_MAX (LINE_MAX)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .rd_idx_i   (rd_idx),
    .st_o       (st),
    .col_o      (col),
    .width_o    (width)
  );

endmodule

`default_nettype wire

// ----- rtl/hdf_checker.sv -----
`default_nettype none

module hdf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] char_a_i,
  input wire logic [7:0] char_b_i,
  input wire logic [7:0] char_c_i,
  input wire logic [7:0] char_d_i,
  input wire logic [2:0] char_count_i,
  input wire logic       run_end_i
);

  // Every item carries one to four characters.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_count_i == 3'd1 || char_count_i == 3'd2 ||
                     char_count_i == 3'd3 || char_count_i == 3'd4))
    else $error("item character count out of range");

  // Only the final item of a run may be short.
  a_short_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_count_i != 3'd4 |-> run_end_i)
    else $error("short item before the end of a run");

  // Unused character positions read as zero.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (char_count_i == 3'd4 || char_d_i == 8'h00) &&
                    (char_count_i == 3'd4 || char_count_i == 3'd3 || char_c_i == 8'h00) &&
                    (char_count_i != 3'd1 || char_b_i == 8'h00))
    else $error("character beyond the count is not zero");

  // Each byte gives several characters, so input is never taken twice in a row.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  // A stalled item is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_a_i) &&
      $stable(char_b_i) && $stable(char_c_i) && $stable(char_d_i) &&
      $stable(char_count_i) && $stable(run_end_i))
    else $error("stalled item changed");

endmodule

bind hex_dump_formatter_unit hdf_checker u_hdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .char_a_i     (out_o.char_a),
  .char_b_i     (out_o.char_b),
  .char_c_i     (out_o.char_c),
  .char_d_i     (out_o.char_d),
  .char_count_i (out_o.char_count),
  .run_end_i    (out_o.run_end)
);

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hdf_pkg::*;

  // One byte of a dump as it waits to be sent.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } dump_byte_t;

  // One packed text item as it leaves the block.
  typedef struct packed {
    logic [7:0] char_a;
    logic [7:0] char_b;
    logic [7:0] char_c;
    logic [7:0] char_d;
    logic [2:0] char_count;
    logic       run_end;
  } text_item_t;

  localparam logic [127:0] HEX_TEXT = "0123456789ABCDEF";

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hdf_in_if  in_bus ();
  hdf_out_if out_bus ();

  hex_dump_formatter_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Bytes still to be sent and text items still to arrive.
  dump_byte_t pending_bytes[$];
  text_item_t expected_text[$];

  // Shadow copy of the registers and the line state of the formatter.
  logic [31:0]   base_reg  = '0;
  logic [LW_W-1:0] width_reg = LW_RESET;
  logic [31:0]   line_addr = '0;
  int unsigned   col_idx   = 0;
  logic          dump_on   = 1'b0;
  logic [7:0]    line_buf [LINE_MAX_DEF];

  // Idling controls, changed between phases.
  int  gap_pct    = 0;
  int  stall_pct  = 0;
  bit  calm       = 1'b0;
  int  gap_left   = 0;
  int  stall_left = 0;
  int  mismatches = 0;

  logic [7:0] corner_bytes [8] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'h0A};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] hex_of(input logic [3:0] n);
    return HEX_TEXT[(15 - n) * 8 +: 8];
  endfunction

  // Works out the text caused by one byte and queues it as packed items.
  function automatic void format_byte(input logic [7:0] b, input logic last);
    logic [7:0]  txt[$];
    int unsigned w;
    int unsigned col;
    int unsigned items;
    int unsigned cnt;
    text_item_t  it;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_MAX_DEF) w = LINE_MAX_DEF;
    if (!dump_on) begin
      dump_on   = 1'b1;
      line_addr = base_reg;
      col_idx   = 0;
    end
    col = col_idx;
    if (col >= LINE_MAX_DEF) col = LINE_MAX_DEF - 1;

    // A new line opens with its address.
    if (col == 0) begin
      for (int s = 7; s >= 0; s--) txt.push_back(hex_of(line_addr[s*4 +: 4]));
      repeat (3) txt.push_back(CHAR_SPACE);
    end

    line_buf[col] = b;
    txt.push_back(hex_of(b[7:4]));
    txt.push_back(hex_of(b[3:0]));
    txt.push_back(CHAR_SPACE);
    if (((col + 1) & 3) == 0) txt.push_back(CHAR_SPACE);

    // Closing a line: padding, gap, ASCII column and line end.
    if (last || (col + 1 >= w)) begin
      for (int unsigned j = col + 1; j < w; j++) begin
        repeat (3) txt.push_back(CHAR_SPACE);
        if (((j + 1) & 3) == 0) txt.push_back(CHAR_SPACE);
      end
      if ((w & 3) != 0) txt.push_back(CHAR_SPACE);
      for (int unsigned j = 0; j <= col; j++) begin
        if (line_buf[j] >= CHAR_SPACE && line_buf[j] <= CHAR_DEL) txt.push_back(line_buf[j]);
        else txt.push_back(CHAR_DOT);
      end
      txt.push_back(CHAR_CR);
      txt.push_back(CHAR_LF);
      line_addr = line_addr + w;
      col_idx   = 0;
      if (last) dump_on = 1'b0;
    end else begin
      col_idx = col + 1;
    end

    // Pack four characters to an item, unused positions zero.
    items = (txt.size() + 3) / 4;
    for (int unsigned k = 0; k < items; k++) begin
      cnt = txt.size() - 4 * k;
      if (cnt > 4) cnt = 4;
      it.char_a     = txt[4*k];
      it.char_b     = (cnt > 1) ? txt[4*k+1] : 8'h00;
      it.char_c     = (cnt > 2) ? txt[4*k+2] : 8'h00;
      it.char_d     = (cnt > 3) ? txt[4*k+3] : 8'h00;
      it.char_count = cnt[2:0];
      it.run_end    = (k + 1 == items);
      expected_text.push_back(it);
    end
  endfunction

  // Byte driver: predicts on each transfer and inserts random gaps.
  always @(posedge clk) begin : byte_driver
    dump_byte_t nb;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        format_byte(in_bus.data_byte, in_bus.last_byte);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (!calm && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(14, 0);
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nb = pending_bytes.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= nb.data;
          in_bus.last_byte <= nb.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Text monitor: checks each transfer against the oldest expected item.
  always @(posedge clk) begin : text_monitor
    text_item_t got;
    text_item_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.char_a, out_bus.char_b, out_bus.char_c, out_bus.char_d,
                out_bus.char_count, out_bus.run_end};
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item %h %h %h %h count %0d end %0b", $realtime,
                     got.char_a, got.char_b, got.char_c, got.char_d,
                     got.char_count, got.run_end);
        end else begin
          want = expected_text.pop_front();
          if (got.char_a !== want.char_a || got.char_b !== want.char_b ||
              got.char_c !== want.char_c || got.char_d !== want.char_d ||
              got.char_count !== want.char_count || got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected %h %h %h %h count %0d end %0b, got %h %h %h %h count %0d end %0b",
                       $realtime, want.char_a, want.char_b, want.char_c, want.char_d,
                       want.char_count, want.run_end, got.char_a, got.char_b,
                       got.char_c, got.char_d, got.char_count, got.run_end);
          end
        end
      end
      if (stall_left > 0 && !calm) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(14, 0);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic last);
    dump_byte_t nb;
    nb.data = data;
    nb.last = last;
    pending_bytes.push_back(nb);
  endtask

  // Waits until every byte is sent and every item has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_bus.valid || expected_text.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) base_reg = value;
    else width_reg = value[LW_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return corner_bytes[$urandom_range(7)];
    if (r < 6) return 8'($urandom_range(8'h7E, 8'h20));
    return 8'($urandom_range(255));
  endfunction

  // Stimulus: directed cases, then random phases of whole dumps.
  initial begin : stimulus
    int sent;
    int phase_target;
    int phase_sent;
    int len;
    logic [LW_W-1:0] w;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single-byte dump at the reset settings: a line padded all the way.
    push_byte(8'h00, 1'b1);
    wait_idle();

    // Address wrap across two lines, ASCII bounds in the bytes.
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFF8);
    write_reg(CFG_LINE_WIDTH, 32'd8);
    foreach (corner_bytes[i]) push_byte(corner_bytes[i], 1'b0);
    push_byte(8'h55, 1'b1);
    wait_idle();

    // Width zero behaves as one byte per line.
    write_reg(CFG_BASE_ADDRESS, 32'h1234_5678);
    write_reg(CFG_LINE_WIDTH, 32'd0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h7F, 1'b1);
    wait_idle();

    // Width above the store depth, then narrowed in mid-line.
    write_reg(CFG_LINE_WIDTH, 32'hFFFF_FFFF);
    push_byte(8'h30, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h20, 1'b0);
    wait_idle();
    write_reg(CFG_LINE_WIDTH, 32'd2);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h01, 1'b1);
    wait_idle();

    // Width not a multiple of four, dump running onto a second line.
    write_reg(CFG_BASE_ADDRESS, 32'hA5A5_A5A5);
    write_reg(CFG_LINE_WIDTH, 32'd5);
    for (int i = 0; i < 6; i++) push_byte(8'($urandom_range(255)), i == 5);
    wait_idle();
    write_reg(CFG_LINE_WIDTH, 32'd4);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Random phases; each waits for the block to drain first.
    sent = 0;
    while (sent < 330) begin
      wait_idle();
      calm = (sent >= 270);
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(5))
          0: w = 5'd0;
          1: w = 5'd1;
          2: w = 5'd16;
          3: w = 5'($urandom_range(31, 17));
          default: w = 5'($urandom_range(16, 1));
        endcase
        write_reg(CFG_LINE_WIDTH, ($urandom & ~32'h1F) | {27'd0, w});
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(3))
          0: write_reg(CFG_BASE_ADDRESS, 32'h0000_0000);
          1: write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF - $urandom_range(40));
          default: write_reg(CFG_BASE_ADDRESS, $urandom);
        endcase
      end
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 50;
      endcase
      phase_target = $urandom_range(60, 20);
      phase_sent = 0;
      while (phase_sent < phase_target) begin
        len = ($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(48, 13);
        for (int i = 0; i < len; i++) push_byte(pick_byte(), i == len - 1);
        phase_sent += len;
      end
      // Sometimes leave a line open so the next settings apply in mid-line.
      if ($urandom_range(9) < 3) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) push_byte(pick_byte(), 1'b0);
        phase_sent += len;
      end
      sent += phase_sent;
    end

    // Drain, then allow the longest line time for any stray item.
    wait_idle();
    repeat (120) @(negedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- hex_dump_formatter_unit.f -----
rtl/hdf_pkg.sv
rtl/hdf_stream_if.sv
rtl/hdf_ctrl.sv
rtl/hdf_datapath.sv
rtl/hex_dump_formatter_unit.sv
rtl/hdf_checker.sv
test/tb_top.sv
